FILE: rtl/sv39ptm_pkg.sv
package sv39ptm_pkg;

  // Table geometry
  localparam int TABLE_PAGES_DEF   = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int PPN_W             = 44;
  localparam int VPN_W             = 26;
  localparam int ENTRY_W           = 64;

  // Command modes (mode 3 acts as lookup)
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_MAP    = 2'd1;
  localparam logic [1:0] MODE_UNMAP  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMAPPED  = 2'd1,
    ST_BAD_ENTRY = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    WS_CLEAR,
    WS_IDLE,
    WS_CHECK,
    WS_ZERO,
    WS_LINK,
    WS_READ,
    WS_LEAF
  } walk_state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VPN_W-1:0] virt_page;
    logic [PPN_W-1:0] phys_page;
    logic [7:0]       perm;
    logic             free_on_unmap;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [PPN_W-1:0]   freed_page;
    logic               freed_valid;
  } rsp_t;

endpackage

FILE: rtl/sv39ptm_store.sv
module sv39ptm_store import sv39ptm_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [$clog2(TABLE_PAGES)+IDX_W-1:0]       waddr,
  input  logic [ENTRY_W-1:0]                         wdata,
  input  logic [$clog2(TABLE_PAGES)+IDX_W-1:0]       raddr,
  output logic [ENTRY_W-1:0]                         rdata
);

  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // One write port, one registered read port; read returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sv39ptm_walker.sv
module sv39ptm_walker import sv39ptm_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  req_t                                 req,
  input  logic [PPN_W-1:0]                     base,
  output logic                                 done,
  output rsp_t                                 rsp,
  output logic                                 mem_we,
  output logic [$clog2(TABLE_PAGES)+IDX_W-1:0] mem_waddr,
  output logic [ENTRY_W-1:0]                   mem_wdata,
  output logic [$clog2(TABLE_PAGES)+IDX_W-1:0] mem_raddr,
  input  logic [ENTRY_W-1:0]                   mem_rdata
);

  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int AW    = PW + IDX_W;
  localparam int CW    = $clog2(TABLE_PAGES + 1);
  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

  walk_state_t     state, state_next;
  logic [1:0]      lvl, lvl_next;
  logic [PW-1:0]   page, page_next;
  logic [CW-1:0]   nf, nf_next;
  logic [AW-1:0]   sweep, sweep_next;
  logic [AW-1:0]   link_addr, link_addr_next;
  req_t            cmd, cmd_next;
  logic            done_next;
  rsp_t            rsp_next;

  logic [PPN_W-1:0] child;
  logic [PPN_W-1:0] link_ppn;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] sub_idx;

  // Walk index of a virtual page at a given level
  function automatic logic [IDX_W-1:0] vpn_index(input logic [VPN_W-1:0] vp,
                                                 input logic [1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      2'd2:    idx = {1'b0, vp[25:18]};
      2'd1:    idx = vp[17:9];
      default: idx = vp[8:0];
    endcase
    return idx;
  endfunction

  assign cur_idx  = vpn_index(cmd.virt_page, lvl);
  assign sub_idx  = vpn_index(cmd.virt_page, lvl - 2'd1);
  assign child    = mem_rdata[53:10] - base;
  assign link_ppn = base + PPN_W'(page);
  assign busy     = (state != WS_IDLE);

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WS_CLEAR;
      nf    <= CW'(1);
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      nf    <= nf_next;
      sweep <= sweep_next;
      done  <= done_next;
    end
    lvl       <= lvl_next;
    page      <= page_next;
    link_addr <= link_addr_next;
    cmd       <= cmd_next;
    rsp       <= rsp_next;
  end

  // Next state, memory access and result
  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    page_next      = page;
    nf_next        = nf;
    sweep_next     = sweep;
    link_addr_next = link_addr;
    cmd_next       = cmd;
    done_next      = 1'b0;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = {page, cur_idx};

    case (state)
      // zero the whole store after reset
      WS_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = sweep;
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(DEPTH - 1)) begin
          state_next = WS_IDLE;
        end
      end

      // take a command, fetch the root entry
      WS_IDLE: begin
        if (start) begin
          cmd_next   = req;
          lvl_next   = 2'd2;
          page_next  = '0;
          mem_raddr  = {{PW{1'b0}}, vpn_index(req.virt_page, 2'd2)};
          state_next = WS_CHECK;
        end
      end

      // intermediate entry of level 2 or 1 is on the read port
      WS_CHECK: begin
        if (mem_rdata[0]) begin
          if ((|mem_rdata[3:1]) || (child >= PPN_W'(TABLE_PAGES))) begin
            done_next  = 1'b1;
            rsp_next   = '{status: ST_BAD_ENTRY, leaf_entry: '0,
                           freed_page: '0, freed_valid: 1'b0};
            state_next = WS_IDLE;
          end else begin
            page_next  = child[PW-1:0];
            lvl_next   = lvl - 2'd1;
            mem_raddr  = {child[PW-1:0], sub_idx};
            state_next = (lvl == 2'd1) ? WS_LEAF : WS_CHECK;
          end
        end else if (cmd.mode != MODE_MAP) begin
          done_next  = 1'b1;
          rsp_next   = '{status: ST_UNMAPPED, leaf_entry: '0,
                         freed_page: '0, freed_valid: 1'b0};
          state_next = WS_IDLE;
        end else if (nf >= CW'(TABLE_PAGES)) begin
          done_next  = 1'b1;
          rsp_next   = '{status: ST_FULL, leaf_entry: '0,
                         freed_page: '0, freed_valid: 1'b0};
          state_next = WS_IDLE;
        end else begin
          // allocate the next table page
          link_addr_next = {page, cur_idx};
          page_next      = nf[PW-1:0];
          nf_next        = nf + CW'(1);
          sweep_next     = '0;
          state_next     = WS_ZERO;
        end
      end

      // clear the fresh page, one entry a cycle
      WS_ZERO: begin
        mem_we     = 1'b1;
        mem_waddr  = {page, sweep[IDX_W-1:0]};
        sweep_next = sweep + AW'(1);
        if (&sweep[IDX_W-1:0]) begin
          state_next = WS_LINK;
        end
      end

      // point the parent entry at the fresh page
      WS_LINK: begin
        mem_we     = 1'b1;
        mem_waddr  = link_addr;
        mem_wdata  = {10'd0, link_ppn, 9'd0, 1'b1};
        lvl_next   = lvl - 2'd1;
        state_next = WS_READ;
      end

      // re-issue the read after a link write
      WS_READ: begin
        state_next = (lvl == 2'd0) ? WS_LEAF : WS_CHECK;
      end

      // leaf entry is on the read port
      WS_LEAF: begin
        done_next  = 1'b1;
        state_next = WS_IDLE;
        rsp_next   = '{status: ST_OK, leaf_entry: mem_rdata,
                       freed_page: '0, freed_valid: 1'b0};
        if (cmd.mode == MODE_MAP) begin
          mem_we    = 1'b1;
          mem_waddr = {page, cur_idx};
          mem_wdata = {10'd0, cmd.phys_page, 2'b00, cmd.perm[7:1], 1'b1};
          rsp_next.leaf_entry = mem_wdata;
        end else if (cmd.mode == MODE_UNMAP) begin
          if (!mem_rdata[0]) begin
            rsp_next.status     = ST_UNMAPPED;
            rsp_next.leaf_entry = '0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = {page, cur_idx};
            if (cmd.free_on_unmap) begin
              rsp_next.freed_page  = mem_rdata[53:10];
              rsp_next.freed_valid = 1'b1;
            end
          end
        end
      end

      default: begin
        state_next = WS_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sv39_page_table_maintainer_unit.sv
// Channel   | Signals                        | Handshake
// ----------+--------------------------------+----------------------------------
// command   | start, busy, req               | word taken when start && !busy
// result    | done, rsp                      | one-cycle strobe, cannot stall
// config    | cfg_valid, cfg_ready, cfg_data | written when cfg_valid && cfg_ready
//
// After reset the store is swept to zero, one entry a cycle, with busy high.
// A full walk then runs from acceptance to the next acceptance through three
// dependent reads of the store; a walk that ends in an error at the root or
// middle level stops after the read that found it. done is high in the cycle
// in which busy goes low again. Each fresh table page a map allocates adds a
// 512-entry clear, a link write and a re-read.
module sv39_page_table_maintainer_unit import sv39ptm_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output logic             done,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PPN_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_PAGES) + IDX_W;

  logic [PPN_W-1:0]   table_base_page;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // Base page register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_page <= '0;
    end else if (cfg_valid && cfg_ready) begin
      table_base_page <= cfg_data;
    end
  end

  sv39ptm_walker #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .base      (table_base_page),
    .done      (done),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sv39ptm_store #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
